// ===== design/alkd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keypad decoder package
// Key window table, register indexes and reset values shared by the
// resistor-ladder keypad decoder modules.
// ----------------------------------------------------------------------------
package alkd_pkg;

	localparam int SAMPLE_W    = 12;
	localparam int CODE_W      = 8;
	localparam int DB_LIMIT_W  = 8;
	localparam int REP_LIMIT_W = 16;
	localparam int CFG_DATA_W  = 16;
	localparam int NUM_WINDOWS = 17;

	typedef enum logic [0:0] {
		CFG_DEBOUNCE_LIMIT = 1'b0,
		CFG_REPEAT_LIMIT   = 1'b1
	} cfg_index_t;

	localparam logic [DB_LIMIT_W-1:0]  DB_LIMIT_RESET  = 8'd20;
	localparam logic [REP_LIMIT_W-1:0] REP_LIMIT_RESET = 16'd7500;

	typedef struct packed {
		logic [SAMPLE_W-1:0] lo;
		logic [SAMPLE_W-1:0] hi;
		logic [CODE_W-1:0]   code;
	} key_window_t;

	// Open intervals; the first matching window wins.
	localparam key_window_t WINDOWS [NUM_WINDOWS] = '{
		'{12'd2390, 12'd2490, 8'h2A},
		'{12'd2810, 12'd2910, 8'h23},
		'{12'd3640, 12'd3740, 8'h79},
		'{12'd3230, 12'd3330, 8'h78},
		'{12'd3420, 12'd3520, 8'h7A},
		'{12'd3840, 12'd3940, 8'h6F},
		'{12'd3040, 12'd3140, 8'h73},
		'{12'd2590, 12'd2690, 8'h30},
		'{12'd2190, 12'd2290, 8'h39},
		'{12'd1580, 12'd1680, 8'h36},
		'{12'd970,  12'd1070, 8'h33},
		'{12'd760,  12'd860,  8'h32},
		'{12'd1410, 12'd1510, 8'h35},
		'{12'd1990, 12'd2090, 8'h38},
		'{12'd1810, 12'd1910, 8'h37},
		'{12'd1180, 12'd1280, 8'h34},
		'{12'd550,  12'd650,  8'h31}
	};

	// Push handshake from the classifier into the queue.
	typedef struct packed {
		logic              valid;
		logic [CODE_W-1:0] code;
	} q_push_t;

	function automatic logic [CODE_W-1:0] classify(input logic [SAMPLE_W-1:0] v);
		logic [CODE_W-1:0] code;
		code = '0;
		// Walk from the last window back so the earliest match is kept.
		for (int i = NUM_WINDOWS - 1; i >= 0; i--) begin
			if (v > WINDOWS[i].lo && v < WINDOWS[i].hi) begin
				code = WINDOWS[i].code;
			end
		end
		return code;
	endfunction

endpackage

// ===== design/alkd_sample_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sample channel
// Valid/ready channel carrying one raw ADC sample per transaction.
// ----------------------------------------------------------------------------
interface alkd_sample_if
	import alkd_pkg::*;
();
	logic                valid;
	logic                ready;
	logic [SAMPLE_W-1:0] sample;

	modport source (output valid, output sample, input ready);
	modport sink   (input valid, input sample, output ready);
endinterface

// ===== design/alkd_result_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying one key report per transaction.
// ----------------------------------------------------------------------------
interface alkd_result_if
	import alkd_pkg::*;
();
	logic              valid;
	logic              ready;
	logic              key_event;
	logic [CODE_W-1:0] key_code;
	logic              from_repeat;
	logic              key_seen;

	modport source (output valid, output key_event, output key_code,
		output from_repeat, output key_seen, input ready);
	modport sink   (input valid, input key_event, input key_code,
		input from_repeat, input key_seen, output ready);
endinterface

// ===== design/alkd_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keypad classifier
// Accepts samples, matches them against the key windows and hands the key
// code to the queue through one pipeline register.
// ----------------------------------------------------------------------------
module alkd_front
	import alkd_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	alkd_sample_if.sink        sample_ch,
	output q_push_t            push,
	input  logic               q_full
);

	logic              valid_s1;
	logic [CODE_W-1:0] code_s1;
	logic              take;

	assign sample_ch.ready = !valid_s1 || !q_full;
	assign take            = sample_ch.valid && sample_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (!q_full) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			code_s1 <= classify(sample_ch.sample);
		end
	end

	assign push.valid = valid_s1;
	assign push.code  = code_s1;

endmodule

// ===== design/alkd_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Key code queue
// Small FIFO that decouples the classifier from the counter stage.
// ----------------------------------------------------------------------------
module alkd_queue
	import alkd_pkg::*;
#(
	parameter int DEPTH = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  q_push_t           push,
	output logic              full,
	output logic              pop_valid,
	output logic [CODE_W-1:0] pop_code,
	input  logic              pop_ready
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	logic [CODE_W-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              do_push, do_pop;

	assign full      = (count_q == FULL_CNT);
	assign pop_valid = (count_q != '0);
	assign pop_code  = mem_q[rd_ptr_q];
	assign do_push   = push.valid && !full;
	assign do_pop    = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push.code;
		end
	end

endmodule

// ===== design/alkd_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Debounce and repeat counters
// Holds the limit registers, runs the debounce and long-press counters on
// each key code and registers the report for the result channel.
// ----------------------------------------------------------------------------
module alkd_back
	import alkd_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  cfg_index_t            cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  pop_valid,
	input  logic [CODE_W-1:0]     pop_code,
	output logic                  pop_ready,
	alkd_result_if.source         result_ch
);

	logic [DB_LIMIT_W-1:0]  db_limit_q;
	logic [REP_LIMIT_W-1:0] rep_limit_q;

	logic                   pressed_q, repeating_q;
	logic [DB_LIMIT_W-1:0]  db_count_q;
	logic [REP_LIMIT_W-1:0] hold_count_q;

	logic                   pressed_n, repeating_n;
	logic [DB_LIMIT_W-1:0]  db_count_n, db_inc;
	logic [REP_LIMIT_W-1:0] hold_count_n, hold_inc;
	logic                   seen, ev, rep;

	logic                   out_valid_q;
	logic                   event_q, repeat_q, seen_q;
	logic [CODE_W-1:0]      code_q;
	logic                   do_pop;

	assign pop_ready = !out_valid_q || result_ch.ready;
	assign do_pop    = pop_valid && pop_ready;

	always_comb begin
		seen         = (pop_code != '0);
		hold_inc     = hold_count_q + 1'b1;
		db_inc       = db_count_q + 1'b1;
		hold_count_n = hold_count_q;
		repeating_n  = repeating_q;
		db_count_n   = db_count_q;
		pressed_n    = pressed_q;
		ev           = 1'b0;
		rep          = 1'b0;

		if (seen) begin
			if (hold_inc >= rep_limit_q) begin
				hold_count_n = '0;
				repeating_n  = 1'b1;
				ev           = 1'b1;
				rep          = 1'b1;
			end else begin
				hold_count_n = hold_inc;
			end
		end else begin
			hold_count_n = '0;
			repeating_n  = 1'b0;
		end

		// Debouncing is frozen while the repeat counter owns the key.
		if (!repeating_n) begin
			if (seen && !pressed_q) begin
				if (db_inc >= db_limit_q) begin
					db_count_n = '0;
					pressed_n  = 1'b1;
					ev         = 1'b1;
					rep        = 1'b0;
				end else begin
					db_count_n = db_inc;
				end
			end
			if (pressed_q && !seen) begin
				pressed_n = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			db_limit_q   <= DB_LIMIT_RESET;
			rep_limit_q  <= REP_LIMIT_RESET;
			pressed_q    <= 1'b0;
			repeating_q  <= 1'b0;
			db_count_q   <= '0;
			hold_count_q <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_DEBOUNCE_LIMIT: db_limit_q  <= cfg_data[DB_LIMIT_W-1:0];
					CFG_REPEAT_LIMIT:   rep_limit_q <= cfg_data[REP_LIMIT_W-1:0];
					default:            ;
				endcase
			end
			if (do_pop) begin
				pressed_q    <= pressed_n;
				repeating_q  <= repeating_n;
				db_count_q   <= db_count_n;
				hold_count_q <= hold_count_n;
				out_valid_q  <= 1'b1;
			end else if (result_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_pop) begin
			event_q  <= ev;
			repeat_q <= rep;
			seen_q   <= seen;
			code_q   <= ev ? pop_code : '0;
		end
	end

	assign result_ch.valid       = out_valid_q;
	assign result_ch.key_event   = event_q;
	assign result_ch.key_code    = code_q;
	assign result_ch.from_repeat = repeat_q;
	assign result_ch.key_seen    = seen_q;

endmodule

// ===== design/adc_ladder_keypad_debounce.sv =====
`timescale 1ns / 1ps
// A sample passes the classifier register, a queue entry and the output register
// before it is offered as a result. Throughput: one sample per cycle unless the
// result side stalls; each counter update is combinational into one register.
// Reset clears the queue, the counters and the output, and restores the debounce
// limit to 20 and the repeat limit to 7500.
// ----------------------------------------------------------------------------
// Resistor-ladder keypad decoder
// Classifies ADC samples into key codes and reports debounced presses and
// long-press repeats.
// ----------------------------------------------------------------------------
module adc_ladder_keypad_debounce
	import alkd_pkg::*;
#(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic                  clk,
	input  logic                  arst_n,
	alkd_sample_if.sink           sample_ch,
	alkd_result_if.source         result_ch,
	input  logic                  cfg_we,
	input  cfg_index_t            cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	q_push_t           push;
	logic              q_full;
	logic              pop_valid, pop_ready;
	logic [CODE_W-1:0] pop_code;

	alkd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.sample_ch (sample_ch),
		.push      (push),
		.q_full    (q_full)
	);

	alkd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (q_full),
		.pop_valid (pop_valid),
		.pop_code  (pop_code),
		.pop_ready (pop_ready)
	);

	alkd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.pop_valid (pop_valid),
		.pop_code  (pop_code),
		.pop_ready (pop_ready),
		.result_ch (result_ch)
	);

	// A report always names a key that was seen on that sample.
	a_event_has_key: assert property (@(posedge clk) disable iff (!arst_n)
		result_ch.valid && result_ch.key_event |->
			result_ch.key_code != '0 && result_ch.key_seen)
		else $error("key report without a key");

	// Without a report the code and repeat flag stay clear.
	a_idle_clear: assert property (@(posedge clk) disable iff (!arst_n)
		result_ch.valid && !result_ch.key_event |->
			result_ch.key_code == '0 && !result_ch.from_repeat)
		else $error("stale code or repeat flag on a quiet result");

	// The front never holds a classified code while the queue has room.
	a_front_drains: assert property (@(posedge clk) disable iff (!arst_n)
		push.valid && !q_full && !(sample_ch.valid && sample_ch.ready) |=> !push.valid)
		else $error("classifier register failed to drain into the queue");

endmodule

// ===== sim/tb_adc_ladder_keypad_debounce.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keypad decoder testbench
// Streams ADC samples into the keypad decoder under random back-pressure and
// idle cycles and predicts every key report from its own copy of the window
// table, debounce counter and long-press counter. The run moves through
// several limit settings, from the reset values to zero, one and the largest.
// ----------------------------------------------------------------------------
module tb_adc_ladder_keypad_debounce;
	import alkd_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int IDLE_PCT    = 23;

	typedef struct packed {
		logic              key_event;
		logic [CODE_W-1:0] key_code;
		logic              from_repeat;
		logic              key_seen;
	} key_report_t;

	// Predicts one key report per accepted sample and checks the reports in order.
	class key_report_board;
		logic [DB_LIMIT_W-1:0]  db_limit;
		logic [REP_LIMIT_W-1:0] rep_limit;
		logic                   pressed;
		logic [DB_LIMIT_W-1:0]  db_cnt;
		logic [REP_LIMIT_W-1:0] hold_cnt;
		logic                   repeating;
		key_report_t            expected_q[$];
		int                     mismatches;

		function new();
			db_limit   = DB_LIMIT_RESET;
			rep_limit  = REP_LIMIT_RESET;
			pressed    = 1'b0;
			db_cnt     = '0;
			hold_cnt   = '0;
			repeating  = 1'b0;
			mismatches = 0;
		endfunction

		function void set_limit(cfg_index_t idx, logic [CFG_DATA_W-1:0] data);
			if (idx == CFG_DEBOUNCE_LIMIT) begin
				db_limit = data[DB_LIMIT_W-1:0];
			end else begin
				rep_limit = data[REP_LIMIT_W-1:0];
			end
		endfunction

		function logic [CODE_W-1:0] decode_key(logic [SAMPLE_W-1:0] v);
			logic [CODE_W-1:0] code;
			code = '0;
			// Windows are open intervals and the earliest match in the table wins.
			for (int i = 0; i < NUM_WINDOWS; i++) begin
				if (code == '0 && v > WINDOWS[i].lo && v < WINDOWS[i].hi) begin
					code = WINDOWS[i].code;
				end
			end
			return code;
		endfunction

		function void note_sample(logic [SAMPLE_W-1:0] v);
			key_report_t       r;
			logic [CODE_W-1:0] code;
			code = decode_key(v);
			r = '0;
			r.key_seen = (code != '0);
			if (code != '0) begin
				hold_cnt = hold_cnt + 1'b1;
				if (hold_cnt >= rep_limit) begin
					hold_cnt      = '0;
					repeating     = 1'b1;
					r.key_event   = 1'b1;
					r.from_repeat = 1'b1;
					r.key_code    = code;
				end
			end else begin
				hold_cnt  = '0;
				repeating = 1'b0;
			end
			// Debouncing is frozen while the repeat counter owns the key.
			if (!repeating) begin
				if (code != '0 && !pressed) begin
					db_cnt = db_cnt + 1'b1;
					if (db_cnt >= db_limit) begin
						db_cnt        = '0;
						pressed       = 1'b1;
						r.key_event   = 1'b1;
						r.from_repeat = 1'b0;
						r.key_code    = code;
					end
				end
				if (pressed && code == '0) begin
					pressed = 1'b0;
				end
			end
			expected_q.push_back(r);
		endfunction

		function void flag(string what, key_report_t want, key_report_t got);
			mismatches++;
			if (mismatches <= 10) begin
				$display("%s: expected event=%0b code=%02h repeat=%0b seen=%0b,", what,
					want.key_event, want.key_code, want.from_repeat, want.key_seen);
				$display("    got event=%0b code=%02h repeat=%0b seen=%0b",
					got.key_event, got.key_code, got.from_repeat, got.key_seen);
			end
		endfunction

		function void check_result(key_report_t got);
			key_report_t want;
			if (expected_q.size() == 0) begin
				flag("unexpected key report", '0, got);
			end else begin
				want = expected_q.pop_front();
				if (got.key_event !== want.key_event || got.key_code !== want.key_code ||
					got.from_repeat !== want.from_repeat || got.key_seen !== want.key_seen) begin
					flag("key report differs", want, got);
				end
			end
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	cfg_index_t            cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	alkd_sample_if sample_ch ();
	alkd_result_if result_ch ();

	key_report_board board = new();

	bit idle_on       = 1'b1;
	int hold_off_req  = 0;
	int samples_sent  = 0;
	int cycles        = 0;

	adc_ladder_keypad_debounce uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.sample_ch (sample_ch),
		.result_ch (result_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("adc_ladder_keypad_debounce: mismatch");
			$finish;
		end
	end

	// Result side: checks each transaction and applies random or requested stalls.
	initial begin : result_sink
		int stall_left;
		stall_left = 0;
		result_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && result_ch.valid && result_ch.ready) begin
				board.check_result(key_report_t'{result_ch.key_event, result_ch.key_code,
					result_ch.from_repeat, result_ch.key_seen});
			end
			if (hold_off_req > 0) begin
				stall_left   = hold_off_req;
				hold_off_req = 0;
			end
			if (stall_left > 0) begin
				result_ch.ready <= 1'b0;
				stall_left--;
			end else begin
				result_ch.ready <= !(idle_on && $urandom_range(99) < IDLE_PCT);
			end
		end
	end

	task automatic send_sample(input logic [SAMPLE_W-1:0] v);
		while (idle_on && $urandom_range(99) < IDLE_PCT) begin
			sample_ch.valid <= 1'b0;
			@(posedge clk);
		end
		sample_ch.valid  <= 1'b1;
		sample_ch.sample <= v;
		@(posedge clk);
		while (!sample_ch.ready) @(posedge clk);
		board.note_sample(v);
		samples_sent++;
	endtask

	task automatic drain();
		sample_ch.valid <= 1'b0;
		while (board.expected_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_limits(input logic [CFG_DATA_W-1:0] db, input logic [CFG_DATA_W-1:0] rep);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_DEBOUNCE_LIMIT;
		cfg_data  <= db;
		@(posedge clk);
		cfg_index <= CFG_REPEAT_LIMIT;
		cfg_data  <= rep;
		@(posedge clk);
		cfg_we <= 1'b0;
		board.set_limit(CFG_DEBOUNCE_LIMIT, db);
		board.set_limit(CFG_REPEAT_LIMIT, rep);
	endtask

	function automatic logic [SAMPLE_W-1:0] key_sample(int w);
		return SAMPLE_W'(WINDOWS[w].lo + 1 +
			$urandom_range(WINDOWS[w].hi - WINDOWS[w].lo - 2));
	endfunction

	// Mostly no-key levels, including the window edges themselves.
	function automatic logic [SAMPLE_W-1:0] release_sample();
		case ($urandom_range(4))
			0: return '0;
			1: return '1;
			2: return WINDOWS[$urandom_range(NUM_WINDOWS - 1)].lo;
			3: return WINDOWS[$urandom_range(NUM_WINDOWS - 1)].hi;
			default: return SAMPLE_W'($urandom_range(4095));
		endcase
	endfunction

	task automatic press_and_release(input int cap);
		int w;
		int len;
		w   = $urandom_range(NUM_WINDOWS - 1);
		len = $urandom_range(cap, 1);
		for (int i = 0; i < len; i++) begin
			// Occasionally slide to another randomly chosen key without letting go.
			if ($urandom_range(19) == 0) begin
				w = $urandom_range(NUM_WINDOWS - 1);
			end
			send_sample(key_sample(w));
		end
		repeat ($urandom_range(4, 1)) send_sample(release_sample());
	endtask

	task automatic random_phase(input int n, input int cap);
		int start;
		start = samples_sent;
		while (samples_sent - start < n) begin
			if ($urandom_range(99) < 80) begin
				press_and_release(cap);
			end else begin
				repeat ($urandom_range(5, 1)) send_sample(SAMPLE_W'($urandom_range(4095)));
			end
		end
	endtask

	initial begin : stimulus
		arst_n           <= 1'b0;
		cfg_we           <= 1'b0;
		cfg_index        <= CFG_DEBOUNCE_LIMIT;
		cfg_data         <= '0;
		sample_ch.valid  <= 1'b0;
		sample_ch.sample <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset limits: every key once, then window edges. The debounce count runs
		// across different keys, so the twentieth key sample gives the first report.
		send_sample('0);
		send_sample('1);
		for (int w = 0; w < NUM_WINDOWS; w++) begin
			send_sample(SAMPLE_W'((WINDOWS[w].lo + WINDOWS[w].hi) / 2));
		end
		send_sample(WINDOWS[0].lo);
		send_sample(SAMPLE_W'(WINDOWS[0].lo + 1));
		send_sample(SAMPLE_W'(WINDOWS[0].hi - 1));
		send_sample(WINDOWS[0].hi);
		send_sample(SAMPLE_W'(WINDOWS[5].hi - 1));
		send_sample(WINDOWS[16].lo);
		random_phase(80, 80);

		drain();
		set_limits(16'd1, 16'd1);
		random_phase(120, 8);

		drain();
		set_limits(16'd0, 16'd0);
		random_phase(100, 8);

		// Repeat limit below the debounce limit.
		drain();
		set_limits(16'd3, 16'd2);
		random_phase(120, 12);

		drain();
		set_limits(16'd255, 16'd65535);
		random_phase(100, 300);

		// Lowered limits catch the partial counts left over from the last phase.
		// No random idling here, and the result side holds off for a long stretch.
		drain();
		set_limits(16'd4, 16'd6);
		idle_on      = 1'b0;
		hold_off_req = 80;
		random_phase(120, 20);
		idle_on = 1'b1;

		// Upper data bits are ignored by the 8-bit debounce limit.
		drain();
		set_limits({8'hA5, 8'($urandom_range(12, 1))}, 16'($urandom_range(40, 1)));
		random_phase(120, 60);

		drain();
		repeat (10) @(posedge clk);
		if (board.mismatches == 0) begin
			$display("adc_ladder_keypad_debounce: match");
		end else begin
			$display("adc_ladder_keypad_debounce: mismatch");
		end
		$finish;
	end

endmodule

// ===== files.f =====
design/alkd_pkg.sv
design/alkd_sample_if.sv
design/alkd_result_if.sv
design/alkd_front.sv
design/alkd_queue.sv
design/alkd_back.sv
design/adc_ladder_keypad_debounce.sv
sim/tb_adc_ladder_keypad_debounce.sv
